// ===== src/wht_pkg.sv =====
// Shared types and constants of the Walsh-Hadamard sync detector.
package wht_pkg;

   localparam int COEF_WIDTH   = 23;
   localparam int BIN_WIDTH    = 6;
   localparam int THRESH_WIDTH = 22;
   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 22'd19000;

   // Butterfly operation on one element of a stage.
   typedef enum logic [1:0] {
      BF_PASS,
      BF_SUM,
      BF_DIFF
   } bf_op_type;

   typedef struct packed {
      logic      load_wr;   // write an accepted sample into bank 0
      logic      bf_rd;     // butterfly read, result written in the following cycle
      bf_op_type op;
      logic      bank;      // bank read this cycle
      logic      nrg_abs;   // energy pipeline steps
      logic      nrg_sq;
      logic      nrg_cmp;
      logic      out_rd;    // read one result into the output queue
   } wht_cmd_type;

   typedef struct packed {
      logic out_room;       // output queue can take one more read
      logic out_idle;       // output queue empty, nothing in flight
   } wht_status_type;

endpackage

// ===== src/walsh_hadamard_sync_detector.sv =====
// Top level of the Walsh-Hadamard sync detector.
// Collects BLOCK_SIZE complex samples (one item per cycle while loading), then runs an
// unnormalized fast Walsh-Hadamard transform in natural Hadamard order on I and Q,
// checks the energy of the last bin against the square of the threshold register, and
// emits BLOCK_SIZE results, bin 0 first, all carrying the same sync flag. Each transform
// stage passes over every element once through a work memory with a single write port,
// one element per cycle, then a turnaround state. Results stream at one per cycle when
// not stalled; no sample is taken while a block is in the transform or being read out.
// The threshold register must be written only while the block is idle.
module walsh_hadamard_sync_detector
   import wht_pkg::*;
#(
   parameter int BLOCK_SIZE   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample_i,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample_q,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [BIN_WIDTH-1:0]            rsp_bin_index,
   output logic signed [COEF_WIDTH-1:0]    rsp_coef_i,
   output logic signed [COEF_WIDTH-1:0]    rsp_coef_q,
   output logic                            rsp_sync_found,
   output logic                            rsp_last_bin,
   input  logic                            csr_wr_en,
   input  logic [THRESH_WIDTH-1:0]         csr_wr_data
);

   localparam int IW = $clog2(BLOCK_SIZE);

   wht_cmd_type    cmd;
   wht_status_type status;
   logic [IW-1:0]  cmd_idx;
   logic [IW-1:0]  cmd_ptr;

   wht_ctrl #(
      .BLOCK_SIZE   (BLOCK_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .cmd_idx   (cmd_idx),
      .cmd_ptr   (cmd_ptr),
      .status    (status)
   );

   wht_dpath #(
      .BLOCK_SIZE   (BLOCK_SIZE),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_sample_i   (req_sample_i),
      .req_sample_q   (req_sample_q),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .cmd_idx        (cmd_idx),
      .cmd_ptr        (cmd_ptr),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_coef_i     (rsp_coef_i),
      .rsp_coef_q     (rsp_coef_q),
      .rsp_sync_found (rsp_sync_found),
      .rsp_last_bin   (rsp_last_bin)
   );

   // Sample loading never overlaps readout of the previous block.
   a_no_load_during_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("sample taken while results pending");

   // Readout requests only issue when the output queue has space.
   a_out_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_rd |-> status.out_room)
      else $error("output queue overrun");

   // The sync flag holds steady for all results of a block.
   a_sync_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |-> $stable(rsp_sync_found))
      else $error("sync flag changed during readout");

   // The load, butterfly-read and readout commands are never issued together.
   a_one_source: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_wr, cmd.bf_rd, cmd.out_rd}))
      else $error("conflicting datapath commands");

endmodule

// ===== src/wht_ctrl.sv =====
// Sequencer: sample load, transform stages, energy check and result readout.
module wht_ctrl
   import wht_pkg::*;
#(
   parameter int BLOCK_SIZE   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   output wht_cmd_type                     cmd,
   output logic [$clog2(BLOCK_SIZE)-1:0]   cmd_idx,
   output logic [$clog2(BLOCK_SIZE)-1:0]   cmd_ptr,
   input  wht_status_type                  status
);

   localparam int IW = $clog2(BLOCK_SIZE);
   localparam int SW = (IW > 1) ? $clog2(IW) : 1;
   localparam logic [IW-1:0] LAST_IDX   = IW'(BLOCK_SIZE - 1);
   localparam logic [SW-1:0] LAST_STAGE = SW'(IW - 1);
   localparam logic          RES_BANK   = 1'(IW % 2);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_STAGE,
      ST_GAP,
      ST_NRG_RD,
      ST_NRG_ABS,
      ST_NRG_SQ,
      ST_NRG_CMP,
      ST_EMIT,
      ST_DRAIN
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [SW-1:0] stage_ff, stage_in;
   logic [IW-1:0] hmask;
   logic [IW-1:0] partner;
   logic          in_range;

   assign hmask    = IW'(1) << stage_ff;
   assign partner  = idx_ff ^ hmask;
   assign in_range = {1'b0, partner} < (IW+1)'(BLOCK_SIZE);
   assign cmd_idx  = idx_ff;
   assign cmd_ptr  = partner;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      stage_in  = stage_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.op    = BF_PASS;
      cmd.bank  = RES_BANK;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall   = 1'b0;
            cmd.load_wr = req_valid;
            if (req_valid) begin
               if (idx_ff == LAST_IDX) begin
                  idx_in   = '0;
                  stage_in = '0;
                  state_in = ST_STAGE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_STAGE: begin
            cmd.bf_rd = 1'b1;
            cmd.bank  = stage_ff[0];
            if ((idx_ff & hmask) != '0) begin
               cmd.op = BF_DIFF;
            end else if (in_range) begin
               cmd.op = BF_SUM;
            end else begin
               cmd.op = BF_PASS;
            end
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_GAP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_GAP: begin
            if (stage_ff == LAST_STAGE) begin
               idx_in   = LAST_IDX;
               state_in = ST_NRG_RD;
            end else begin
               stage_in = stage_ff + 1'b1;
               state_in = ST_STAGE;
            end
         end
         ST_NRG_RD: begin
            state_in = ST_NRG_ABS;
         end
         ST_NRG_ABS: begin
            cmd.nrg_abs = 1'b1;
            state_in    = ST_NRG_SQ;
         end
         ST_NRG_SQ: begin
            cmd.nrg_sq = 1'b1;
            state_in   = ST_NRG_CMP;
         end
         ST_NRG_CMP: begin
            cmd.nrg_cmp = 1'b1;
            idx_in      = '0;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_room) begin
               cmd.out_rd = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  idx_in   = '0;
                  state_in = ST_DRAIN;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (status.out_idle) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         idx_ff   <= '0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         stage_ff <= stage_in;
      end
   end

endmodule

// ===== src/wht_dpath.sv =====
// Datapath: banked work memory, butterfly unit, energy check and output queue.
module wht_dpath
   import wht_pkg::*;
#(
   parameter int BLOCK_SIZE   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample_i,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample_q,
   input  logic                               csr_wr_en,
   input  logic [THRESH_WIDTH-1:0]            csr_wr_data,
   input  wht_cmd_type                        cmd,
   input  logic [$clog2(BLOCK_SIZE)-1:0]      cmd_idx,
   input  logic [$clog2(BLOCK_SIZE)-1:0]      cmd_ptr,
   output wht_status_type                     status,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [BIN_WIDTH-1:0]               rsp_bin_index,
   output logic signed [COEF_WIDTH-1:0]       rsp_coef_i,
   output logic signed [COEF_WIDTH-1:0]       rsp_coef_q,
   output logic                               rsp_sync_found,
   output logic                               rsp_last_bin
);

   localparam int IW = $clog2(BLOCK_SIZE);
   localparam int DW = SAMPLE_WIDTH + IW;
   localparam int AW = (DW > 33) ? DW : 33;
   localparam int EW = (DW > COEF_WIDTH) ? DW : COEF_WIDTH;
   localparam int BW = (IW > BIN_WIDTH) ? IW : BIN_WIDTH;
   localparam int MEM_DEPTH = 2 ** (IW + 1);
   localparam int OQ_DEPTH  = 4;
   localparam int OQ_AW     = 2;
   localparam logic [IW-1:0] LAST_IDX = IW'(BLOCK_SIZE - 1);

   // Work memory: {I, Q} per entry, two banks addressed as {bank, index}
   logic [2*DW-1:0] mem [0:MEM_DEPTH-1];
   logic [2*DW-1:0] rd0_ff, rd1_ff;
   logic [IW:0]     ra0, ra1;
   logic            wr_en;
   logic [IW:0]     wr_addr;
   logic [2*DW-1:0] wr_data;

   logic            bf_vld_ff;
   bf_op_type       op_ff;
   logic            wbank_ff;
   logic [IW-1:0]   pidx_ff;
   logic            push_ff;

   logic [DW-1:0]   i0, q0, i1, q1;
   logic [DW-1:0]   bf_i, bf_q;

   // Energy of the last bin
   logic [THRESH_WIDTH-1:0]   thresh_ff;
   logic [2*THRESH_WIDTH-1:0] thr_sq_ff;
   logic [DW-1:0]   abs_i, abs_q;
   logic [AW-1:0]   absx_i, absx_q;
   logic            sat_i_ff, sat_q_ff;
   logic [31:0]     mag_i_ff, mag_q_ff;
   logic [63:0]     prod_i, prod_q;
   logic [63:0]     sq_i_ff, sq_q_ff;
   logic [64:0]     nrg_sum;
   logic [63:0]     energy;
   logic            sync_ff;

   // Output queue
   logic [BIN_WIDTH-1:0]  oq_bin  [0:OQ_DEPTH-1];
   logic [COEF_WIDTH-1:0] oq_i    [0:OQ_DEPTH-1];
   logic [COEF_WIDTH-1:0] oq_q    [0:OQ_DEPTH-1];
   logic                  oq_last [0:OQ_DEPTH-1];
   logic [OQ_AW-1:0]      wp_ff, rp_ff;
   logic [OQ_AW:0]        occ_ff, occ_in;
   logic                  pop;
   logic signed [EW-1:0]  ext_i, ext_q;
   logic [BW-1:0]         bin_ext;

   assign ra0 = {cmd.bank, cmd_idx};
   assign ra1 = {cmd.bank, cmd_ptr};

   assign i0 = rd0_ff[2*DW-1:DW];
   assign q0 = rd0_ff[DW-1:0];
   assign i1 = rd1_ff[2*DW-1:DW];
   assign q1 = rd1_ff[DW-1:0];

   always_comb begin
      unique case (op_ff)
         BF_SUM: begin
            bf_i = i0 + i1;
            bf_q = q0 + q1;
         end
         BF_DIFF: begin
            bf_i = i1 - i0;
            bf_q = q1 - q0;
         end
         default: begin
            bf_i = i0;
            bf_q = q0;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_wr) begin
         wr_en   = 1'b1;
         wr_addr = {1'b0, cmd_idx};
         wr_data = {DW'(req_sample_i), DW'(req_sample_q)};
      end else begin
         wr_en   = bf_vld_ff;
         wr_addr = {wbank_ff, pidx_ff};
         wr_data = {bf_i, bf_q};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff <= mem[ra0];
      rd1_ff <= mem[ra1];
   end

   always_ff @(posedge clock) begin
      op_ff    <= cmd.op;
      wbank_ff <= ~cmd.bank;
      pidx_ff  <= cmd_idx;
   end

   // Energy: magnitude, saturating square, saturating sum, compare
   assign abs_i  = i0[DW-1] ? (~i0 + 1'b1) : i0;
   assign abs_q  = q0[DW-1] ? (~q0 + 1'b1) : q0;
   assign absx_i = AW'(abs_i);
   assign absx_q = AW'(abs_q);
   assign prod_i = mag_i_ff * mag_i_ff;
   assign prod_q = mag_q_ff * mag_q_ff;
   assign nrg_sum = {1'b0, sq_i_ff} + {1'b0, sq_q_ff};
   assign energy  = nrg_sum[64] ? '1 : nrg_sum[63:0];

   always_ff @(posedge clock) begin
      thr_sq_ff <= thresh_ff * thresh_ff;
      if (cmd.nrg_abs) begin
         sat_i_ff <= |absx_i[AW-1:32];
         sat_q_ff <= |absx_q[AW-1:32];
         mag_i_ff <= absx_i[31:0];
         mag_q_ff <= absx_q[31:0];
      end
      if (cmd.nrg_sq) begin
         sq_i_ff <= sat_i_ff ? '1 : prod_i;
         sq_q_ff <= sat_q_ff ? '1 : prod_q;
      end
   end

   // Output queue push and head
   assign ext_i   = EW'($signed(i0));
   assign ext_q   = EW'($signed(q0));
   assign bin_ext = BW'(pidx_ff);
   assign pop     = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (push_ff) begin
         oq_bin[wp_ff]  <= bin_ext[BIN_WIDTH-1:0];
         oq_i[wp_ff]    <= ext_i[COEF_WIDTH-1:0];
         oq_q[wp_ff]    <= ext_q[COEF_WIDTH-1:0];
         oq_last[wp_ff] <= (pidx_ff == LAST_IDX);
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (push_ff && !pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (pop && !push_ff) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bf_vld_ff <= 1'b0;
         push_ff   <= 1'b0;
         wp_ff     <= '0;
         rp_ff     <= '0;
         occ_ff    <= '0;
         thresh_ff <= THRESH_RESET;
         sync_ff   <= 1'b0;
      end else begin
         bf_vld_ff <= cmd.bf_rd;
         push_ff   <= cmd.out_rd;
         occ_ff    <= occ_in;
         if (push_ff) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (cmd.nrg_cmp) begin
            sync_ff <= (energy >= 64'(thr_sq_ff));
         end
      end
   end

   assign status.out_room = (occ_ff + (OQ_AW+1)'(push_ff)) <= (OQ_AW+1)'(OQ_DEPTH - 2);
   assign status.out_idle = (occ_ff == '0) && !push_ff;

   assign rsp_valid      = (occ_ff != '0);
   assign rsp_bin_index  = oq_bin[rp_ff];
   assign rsp_coef_i     = oq_i[rp_ff];
   assign rsp_coef_q     = oq_q[rp_ff];
   assign rsp_last_bin   = oq_last[rp_ff];
   assign rsp_sync_found = sync_ff;

endmodule
